// ===== src/cosine_taylor_series_top_macros.svh =====
// Assertion helpers shared by the cosine pipeline modules.
// Both expect clk and rst_n in the enclosing module.
`ifndef COSINE_TAYLOR_SERIES_TOP_MACROS_SVH
`define COSINE_TAYLOR_SERIES_TOP_MACROS_SVH

// Same-cycle implication.
`define CTS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CTS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/cts_pkg.sv =====
package cts_pkg;

    localparam int NUM_TERMS_DEF     = 11;
    localparam int OUT_FRAC_BITS_DEF = 16;

    localparam int ANGLE_W    = 18;
    localparam int ANGLE_FRAC = 8;
    localparam int Q_W        = 64;
    localparam int HALF_W     = 32;
    localparam int MAG_W      = 63;
    localparam int MUL_LAT    = 3;
    localparam int DEG2RAD_W  = 28;
    localparam int PROD_W     = ANGLE_W + DEG2RAD_W;

    typedef logic signed [Q_W-1:0]     q32_t;
    typedef logic        [MAG_W-1:0]   qmag_t;
    typedef logic signed [ANGLE_W-1:0] angle_t;

    // +/-360 degrees with 8 fraction bits
    localparam angle_t ANGLE_LIMIT = 18'sd92160;
    // round(pi/180 * 2^32)
    localparam logic signed [DEG2RAD_W-1:0] DEG2RAD_Q32 = 28'sd74961321;
    localparam qmag_t MAG_LIMIT = qmag_t'(1) << 62;
    localparam q32_t  ONE_Q32   = q32_t'(1) << HALF_W;
    // largest |x| in Q32 after conversion of a clamped angle
    localparam q32_t  X_MAX     = 64'sd26986075560;

    // round(2^32 / ((2n-1)(2n))), zero where no term exists
    function automatic logic [HALF_W-1:0] recip_q32(input int n);
        logic [HALF_W-1:0] r;
        unique case (n)
            1:       r = 32'd2147483648;
            2:       r = 32'd357913941;
            3:       r = 32'd143165577;
            4:       r = 32'd76695845;
            5:       r = 32'd47721859;
            6:       r = 32'd32537631;
            7:       r = 32'd23598721;
            8:       r = 32'd17895697;
            9:       r = 32'd14035841;
            10:      r = 32'd11302546;
            11:      r = 32'd9296466;
            12:      r = 32'd7780738;
            13:      r = 32'd6607642;
            14:      r = 32'd5681174;
            15:      r = 32'd4936744;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== src/cts_mul.sv =====
`include "cosine_taylor_series_top_macros.svh"

// Q32 x Q32 -> rounded magnitude and sign, three stages:
// operand magnitudes, 32x32 partial products, combine and saturate.
module cts_mul
    import cts_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  q32_t  a,
    input  q32_t  b,
    output qmag_t mag,
    output logic  neg
);

    logic [Q_W-1:0]    ua_reg, ub_reg, ua_next, ub_next;
    logic              neg1_reg, neg1_next;
    logic [Q_W-1:0]    albl_reg, mid_reg, albh_reg;
    logic [Q_W-1:0]    albl_next, mid_next, albh_next;
    logic              sat_reg, sat_next;
    logic              neg2_reg;
    qmag_t             mag_reg, mag_next;
    logic              neg3_reg;
    logic [HALF_W-1:0] low;
    logic [Q_W:0]      tot;

    always_comb
    begin
        ua_next   = a[Q_W-1] ? Q_W'(-a) : Q_W'(a);
        ub_next   = b[Q_W-1] ? Q_W'(-b) : Q_W'(b);
        neg1_next = a[Q_W-1] ^ b[Q_W-1];

        albl_next = Q_W'(ua_reg[HALF_W-1:0]) * Q_W'(ub_reg[HALF_W-1:0]);
        mid_next  = Q_W'(ua_reg[Q_W-1:HALF_W]) * Q_W'(ub_reg[HALF_W-1:0]);
        albh_next = Q_W'(ua_reg[HALF_W-1:0]) * Q_W'(ub_reg[Q_W-1:HALF_W]);
        // both high halves set: the product is clamped to MAG_LIMIT
        sat_next  = (|ua_reg[Q_W-1:HALF_W]) && (|ub_reg[Q_W-1:HALF_W]);

        low = HALF_W'((albl_reg + (Q_W'(1) << (HALF_W-1))) >> HALF_W);
        // without saturation at most one cross product is nonzero
        tot = {1'b0, mid_reg | albh_reg} + (Q_W+1)'(low);
        if (sat_reg || (tot > (Q_W+1)'(MAG_LIMIT)))
            mag_next = MAG_LIMIT;
        else
            mag_next = MAG_W'(tot);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ua_reg   <= ua_next;
            ub_reg   <= ub_next;
            neg1_reg <= neg1_next;
            albl_reg <= albl_next;
            mid_reg  <= mid_next;
            albh_reg <= albh_next;
            sat_reg  <= sat_next;
            neg2_reg <= neg1_reg;
            mag_reg  <= mag_next;
            neg3_reg <= neg2_reg;
        end
    end

    assign mag = mag_reg;
    assign neg = neg3_reg;

    `CTS_ASSERT_NXT(a_mul_sat, en && sat_reg, mag_reg == MAG_LIMIT, "saturated product not clamped")

endmodule

// ===== src/cts_front.sv =====
`include "cosine_taylor_series_top_macros.svh"

// Clamp, degrees to radians in Q32, then x^2.
module cts_front
    import cts_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   in_valid,
    input  angle_t angle,
    output logic   out_valid,
    output q32_t   x2
);

    localparam int PRE = 4;

    logic [PRE+MUL_LAT-1:0]     vch_reg;
    logic                       valid_reg;
    angle_t                     deg_reg, deg_next;
    logic signed [PROD_W-1:0]   deg_ext, k_ext;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic [PROD_W-1:0]          pmag_reg, pmag_next;
    logic                       pneg_reg;
    logic [PROD_W-1:0]          rnd;
    q32_t                       x_reg, x_next;
    qmag_t                      sq_mag;
    logic                       sq_neg;
    q32_t                       sq_val;
    q32_t                       x2_reg, x2_next;

    always_comb
    begin
        if (angle > ANGLE_LIMIT)
            deg_next = ANGLE_LIMIT;
        else if (angle < -ANGLE_LIMIT)
            deg_next = -ANGLE_LIMIT;
        else
            deg_next = angle;

        deg_ext   = PROD_W'(deg_reg);
        k_ext     = PROD_W'(DEG2RAD_Q32);
        prod_next = deg_ext * k_ext;

        pmag_next = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);

        rnd    = (pmag_reg + (PROD_W'(1) << (ANGLE_FRAC-1))) >> ANGLE_FRAC;
        x_next = pneg_reg ? -q32_t'(rnd) : q32_t'(rnd);

        sq_val  = q32_t'({1'b0, sq_mag});
        x2_next = sq_neg ? -sq_val : sq_val;
    end

    cts_mul u_sq (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .a     (x_reg),
        .b     (x_reg),
        .mag   (sq_mag),
        .neg   (sq_neg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vch_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vch_reg   <= {vch_reg[PRE+MUL_LAT-2:0], in_valid};
            valid_reg <= vch_reg[PRE+MUL_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            deg_reg  <= deg_next;
            prod_reg <= prod_next;
            pmag_reg <= pmag_next;
            pneg_reg <= prod_reg[PROD_W-1];
            x_reg    <= x_next;
            x2_reg   <= x2_next;
        end
    end

    assign out_valid = valid_reg;
    assign x2        = x2_reg;

    `CTS_ASSERT_NXT(a_x_range, en && vch_reg[2],
        (x_reg <= X_MAX) && (x_reg >= -X_MAX), "x beyond 2pi")

endmodule

// ===== src/cts_term.sv =====
// One Horner step: acc' = 1 - t * acc, while the next term's
// t = x^2 * r(n-1) is formed alongside.
module cts_term
    import cts_pkg::*;
#(
    parameter logic [HALF_W-1:0] R_NEXT = '0
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  q32_t acc_in,
    input  q32_t t_in,
    input  q32_t x2_in,
    output logic out_valid,
    output q32_t acc_out,
    output q32_t t_out,
    output q32_t x2_out
);

    logic [MUL_LAT-1:0] vd_reg;
    logic               valid_reg;
    q32_t               x2d_reg [MUL_LAT];
    qmag_t              p_mag, t_mag;
    logic               p_neg, t_neg;
    q32_t               p_val, t_val;
    q32_t               acc_reg, acc_next;
    q32_t               t_reg, t_next;
    q32_t               x2_reg;

    cts_mul u_p (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .a     (t_in),
        .b     (acc_in),
        .mag   (p_mag),
        .neg   (p_neg)
    );

    cts_mul u_t (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .a     (x2_in),
        .b     (q32_t'({{HALF_W{1'b0}}, R_NEXT})),
        .mag   (t_mag),
        .neg   (t_neg)
    );

    always_comb
    begin
        p_val    = q32_t'({1'b0, p_mag});
        acc_next = p_neg ? (ONE_Q32 + p_val) : (ONE_Q32 - p_val);
        t_val    = q32_t'({1'b0, t_mag});
        t_next   = t_neg ? -t_val : t_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vd_reg    <= '0;
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vd_reg    <= {vd_reg[MUL_LAT-2:0], in_valid};
            valid_reg <= vd_reg[MUL_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x2d_reg[0] <= x2_in;
            for (int i = 1; i < MUL_LAT; i++)
            begin
                x2d_reg[i] <= x2d_reg[i-1];
            end
            acc_reg <= acc_next;
            t_reg   <= t_next;
            x2_reg  <= x2d_reg[MUL_LAT-1];
        end
    end

    assign out_valid = valid_reg;
    assign acc_out   = acc_reg;
    assign t_out     = t_reg;
    assign x2_out    = x2_reg;

endmodule

// ===== src/cts_out.sv =====
`include "cosine_taylor_series_top_macros.svh"

// Round Q32 down to the output format and clamp to +/-1.0.
module cts_out
    import cts_pkg::*;
#(
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  q32_t                         acc,
    output logic                         out_valid,
    output logic signed [OUT_FRAC_BITS+1:0] cos_value
);

    localparam int OUT_W = OUT_FRAC_BITS + 2;
    localparam int SHIFT = HALF_W - OUT_FRAC_BITS;
    localparam logic signed [OUT_W-1:0] OUT_ONE = {2'b01, {OUT_FRAC_BITS{1'b0}}};

    logic                    v1_reg, valid_reg;
    logic [Q_W-1:0]          amag_reg, amag_next;
    logic                    aneg_reg;
    logic [Q_W-1:0]          shifted, lim, m;
    logic signed [OUT_W-1:0] res_reg, res_next;

    always_comb
    begin
        amag_next = acc[Q_W-1] ? Q_W'(-acc) : Q_W'(acc);

        shifted  = (amag_reg + (Q_W'(1) << (SHIFT-1))) >> SHIFT;
        lim      = Q_W'(1) << OUT_FRAC_BITS;
        m        = (shifted > lim) ? lim : shifted;
        res_next = aneg_reg ? -OUT_W'(m) : OUT_W'(m);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            valid_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            amag_reg <= amag_next;
            aneg_reg <= acc[Q_W-1];
            res_reg  <= res_next;
        end
    end

    assign out_valid = valid_reg;
    assign cos_value = res_reg;

    `CTS_ASSERT_NXT(a_out_clamp, en && v1_reg && (amag_reg >= Q_W'(ONE_Q32)), (res_reg == OUT_ONE) || (res_reg == -OUT_ONE), "series beyond one not clamped")

endmodule

// ===== src/cosine_taylor_series_top.sv =====
// Cosine of an angle in degrees by an 11-term Maclaurin series.
// Input beat: angle_deg, signed, 8 fraction bits; values beyond +/-360
// degrees are clamped. Output beat: cos_value, signed, OUT_FRAC_BITS
// fraction bits, clamped to +/-1.0.
// Both channels use valid/stall; a beat moves on a clock edge with valid
// high and stall low.
// Pipeline: clamp, radian conversion and squaring, then one Horner step
// per term (a 3-stage Q32 multiplier plus the accumulate register), then
// output rounding.
// Throughput is one beat per cycle; every stage takes a new item each
// cycle while the output is not held.
// Reset clears all valid bits; the pipeline comes up empty.
// While cos_stall holds a pending result the whole pipeline freezes and
// angle_stall is raised in the same cycle, so nothing is dropped.
module cosine_taylor_series_top
    import cts_pkg::*;
#(
    parameter int NUM_TERMS     = NUM_TERMS_DEF,
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic signed [ANGLE_W-1:0]       angle_deg,
    input  logic                            angle_valid,
    output logic                            angle_stall,
    output logic signed [OUT_FRAC_BITS+1:0] cos_value,
    output logic                            cos_valid,
    input  logic                            cos_stall
);

    localparam int OUT_W = OUT_FRAC_BITS + 2;
    localparam logic signed [OUT_W-1:0] OUT_ONE = {2'b01, {OUT_FRAC_BITS{1'b0}}};

    logic             en;
    q32_t             acc_c [NUM_TERMS+1];
    q32_t             t_c   [NUM_TERMS];
    q32_t             x2_c  [NUM_TERMS];
    logic [NUM_TERMS:0] v_c;

    assign en          = !(cos_valid && cos_stall);
    assign angle_stall = !en;

    // head of the chain: t = 0 gives acc = 1.0 out of the first step
    assign acc_c[0] = '0;
    assign t_c[0]   = '0;

    cts_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (angle_valid),
        .angle     (angle_deg),
        .out_valid (v_c[0]),
        .x2        (x2_c[0])
    );

    for (genvar i = 0; i < NUM_TERMS; i++)
    begin : g_term
        if (i < NUM_TERMS - 1)
        begin : g_mid
            cts_term #(
                .R_NEXT (recip_q32(NUM_TERMS - i - 1))
            ) u_term (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (v_c[i]),
                .acc_in    (acc_c[i]),
                .t_in      (t_c[i]),
                .x2_in     (x2_c[i]),
                .out_valid (v_c[i+1]),
                .acc_out   (acc_c[i+1]),
                .t_out     (t_c[i+1]),
                .x2_out    (x2_c[i+1])
            );
        end
        else
        begin : g_last
            cts_term #(
                .R_NEXT (recip_q32(0))
            ) u_term (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (v_c[i]),
                .acc_in    (acc_c[i]),
                .t_in      (t_c[i]),
                .x2_in     (x2_c[i]),
                .out_valid (v_c[i+1]),
                .acc_out   (acc_c[i+1]),
                .t_out     (),
                .x2_out    ()
            );
        end
    end

    cts_out #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_c[NUM_TERMS]),
        .acc       (acc_c[NUM_TERMS]),
        .out_valid (cos_valid),
        .cos_value (cos_value)
    );

    `CTS_ASSERT_IMP(a_cos_range, cos_valid, (cos_value <= OUT_ONE) && (cos_value >= -OUT_ONE), "cosine beyond one")

endmodule

// ===== test/cos_checker.sv =====
`timescale 1ns / 100ps

module cos_checker
    import cts_pkg::*;
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  angle_t                              angle_deg,
    input  logic                                angle_valid,
    input  logic                                angle_stall,
    input  logic signed [OUT_FRAC_BITS_DEF+1:0] cos_value,
    input  logic                                cos_valid,
    input  logic                                cos_stall,
    output int                                  errors,
    output int                                  pending
);

    localparam int          COS_W       = OUT_FRAC_BITS_DEF + 2;
    localparam int          Q_FRAC      = 32;
    localparam longint      ANGLE_MAX   = 92160;
    localparam longint      RAD_PER_DEG = 74961321;   // pi/180 in Q32
    localparam longint      UNITY       = longint'(1) << Q_FRAC;
    localparam logic [63:0] SAT_MAG     = 64'd1 << 62;

    typedef logic signed [COS_W-1:0] cos_t;

    typedef struct packed {
        angle_t angle;
        cos_t   cos;
    } cos_beat_t;

    cos_beat_t cos_expected_q [$];

    function automatic logic [63:0] mag_of(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint signed_mag(input logic [63:0] m, input bit neg);
        if (m > SAT_MAG)
            m = SAT_MAG;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    // right shift, rounding halves away from zero
    function automatic longint round_shift(input longint v, input int s);
        logic [63:0] m;
        m = mag_of(v);
        m = (m + (64'd1 << (s - 1))) >> s;
        return signed_mag(m, v < 0);
    endfunction

    // Q32 x Q32 -> Q32; saturates whenever both operands reach 1.0 in their upper words
    function automatic longint q32_mul(input longint a, input longint b);
        logic [63:0] ua, ub, ah, al, bh, bl, low, mid, sum;
        bit          neg;
        ua  = mag_of(a);
        ub  = mag_of(b);
        ah  = ua >> 32;
        al  = ua & 64'hFFFF_FFFF;
        bh  = ub >> 32;
        bl  = ub & 64'hFFFF_FFFF;
        neg = (a < 0) != (b < 0);
        if (ah != 0 && bh != 0)
            return signed_mag(SAT_MAG, neg);
        low = (al * bl + (64'd1 << 31)) >> 32;
        mid = ah * bl;
        if (mid > SAT_MAG)
            return signed_mag(SAT_MAG, neg);
        sum = mid + al * bh;
        if (sum > SAT_MAG)
            return signed_mag(SAT_MAG, neg);
        sum = sum + low;
        return signed_mag(sum, neg);
    endfunction

    function automatic cos_t cosine_of(input angle_t angle);
        longint deg, x, x2, acc, term, res, d, r;
        deg = longint'(angle);
        if (deg > ANGLE_MAX)
            deg = ANGLE_MAX;
        if (deg < -ANGLE_MAX)
            deg = -ANGLE_MAX;
        x   = round_shift(deg * RAD_PER_DEG, ANGLE_FRAC);
        x2  = q32_mul(x, x);
        acc = UNITY;
        // Horner form: acc = 1 - x^2 / ((2n-1)(2n)) * acc
        for (int n = NUM_TERMS_DEF - 1; n >= 1; n--)
        begin
            d    = longint'(2 * n - 1) * longint'(2 * n);
            r    = (UNITY + d / 2) / d;
            term = q32_mul(x2, r);
            acc  = UNITY - q32_mul(term, acc);
        end
        res = round_shift(acc, Q_FRAC - OUT_FRAC_BITS_DEF);
        if (res > (longint'(1) << OUT_FRAC_BITS_DEF))
            res = longint'(1) << OUT_FRAC_BITS_DEF;
        if (res < -(longint'(1) << OUT_FRAC_BITS_DEF))
            res = -(longint'(1) << OUT_FRAC_BITS_DEF);
        return cos_t'(res);
    endfunction

    always @(posedge clk)
    begin
        cos_beat_t want;
        if (rst_n)
        begin
            if (cos_valid && !cos_stall)
            begin
                if (cos_expected_q.size() == 0)
                begin
                    $display("%0t: unexpected beat: expected none, actual cos_value %0d",
                             $time, cos_value);
                    errors++;
                end
                else
                begin
                    want = cos_expected_q.pop_front();
                    if (cos_value !== want.cos)
                    begin
                        $display("%0t: cos_value mismatch for angle_deg %0d: expected %0d, actual %0d",
                                 $time, want.angle, want.cos, cos_value);
                        errors++;
                    end
                end
            end
            if (angle_valid && !angle_stall)
                cos_expected_q.push_back('{angle_deg, cosine_of(angle_deg)});
            pending = cos_expected_q.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import cts_pkg::*;

    localparam int COS_W        = OUT_FRAC_BITS_DEF + 2;
    localparam int TOTAL_ANGLES = 1950;
    localparam int QUIET_TAIL   = 200;
    localparam int HOLD_AT      = 400;
    localparam int LONG_HOLD    = 200;
    localparam int DRAIN_WAIT   = 4 * NUM_TERMS_DEF + 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int ANGLE_SPAN   = 92160;   // 360 degrees
    localparam int X_UNITY_DEG  = 14668;   // ~57.3 degrees, x near 1.0 rad

    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    angle_t                  angle_deg   = '0;
    logic                    angle_valid = 1'b0;
    logic                    angle_stall;
    logic signed [COS_W-1:0] cos_value;
    logic                    cos_valid;
    logic                    cos_stall   = 1'b0;

    int errors;
    int pending;
    int beats_sent = 0;
    int cycles     = 0;

    cosine_taylor_series_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .angle_deg   (angle_deg),
        .angle_valid (angle_valid),
        .angle_stall (angle_stall),
        .cos_value   (cos_value),
        .cos_valid   (cos_valid),
        .cos_stall   (cos_stall)
    );

    cos_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .angle_deg   (angle_deg),
        .angle_valid (angle_valid),
        .angle_stall (angle_stall),
        .cos_value   (cos_value),
        .cos_valid   (cos_valid),
        .cos_stall   (cos_stall),
        .errors      (errors),
        .pending     (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic angle_t pick_angle();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return angle_t'(int'($urandom_range(0, 2 * ANGLE_SPAN)) - ANGLE_SPAN);
        else if (sel < 7)
            return angle_t'(int'($urandom_range(0, 2 * X_UNITY_DEG)) - X_UNITY_DEG);
        else if (sel < 9)
            return angle_t'($urandom);
        else if ($urandom_range(0, 1) == 0)
            return angle_t'(ANGLE_SPAN + int'($urandom_range(0, 8)) - 4);
        else
            return angle_t'(-ANGLE_SPAN + int'($urandom_range(0, 8)) - 4);
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic offer_angle(input angle_t a);
        angle_deg   <= a;
        angle_valid <= 1'b1;
        do
            @(posedge clk);
        while (angle_stall);
        beats_sent++;
        @(negedge clk);
        if (beats_sent < TOTAL_ANGLES - QUIET_TAIL && $urandom_range(0, 5) == 0)
        begin
            angle_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
    endtask

    task automatic rest_until_drained();
        angle_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    // receiver side: short random stall bursts, one long hold-off to back up the pipe
    initial
    begin
        int stall_left;
        bit held;
        stall_left = 0;
        held       = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left == 0)
            begin
                if (!held && beats_sent >= HOLD_AT)
                begin
                    stall_left = LONG_HOLD;
                    held       = 1'b1;
                end
                else if (beats_sent < TOTAL_ANGLES - QUIET_TAIL && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 7);
            end
            if (stall_left > 0)
            begin
                cos_stall <= 1'b1;
                stall_left--;
            end
            else
                cos_stall <= 1'b0;
        end
    end

    initial
    begin
        angle_t directed [$];
        directed = '{0, 1, -1, ANGLE_SPAN, -ANGLE_SPAN, ANGLE_SPAN + 1, -ANGLE_SPAN - 1,
                     131071, -131072, 23040, -23040, 46080, -46080, 69120, 11520,
                     15360, X_UNITY_DEG - 1, X_UNITY_DEG, -X_UNITY_DEG,
                     18'h2AAAA, 18'h15555, 256, -256};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (directed[i])
            offer_angle(directed[i]);
        rest_until_drained();
        for (int i = directed.size(); i < TOTAL_ANGLES; i++)
        begin
            if (i == TOTAL_ANGLES / 2)
                rest_until_drained();
            offer_angle(pick_angle());
        end
        angle_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
